### rtl/rbb_pkg.sv
package rbb_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SUM_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [10:0] WIDTH_RESET  = 11'd1024;
  localparam logic [15:0] HEIGHT_RESET = 16'd768;

  // floor(x/9) = (x * 7282) >> 16 for x <= 9*255
  localparam logic [12:0] RECIP_NINE = 13'd7282;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sum_t;

  typedef struct packed {
    logic last;
    sum_t sums;
  } s2_t;

  function automatic logic [7:0] div9(input logic [SUM_W-1:0] x);
    logic [SUM_W+12:0] prod;
    prod = {13'd0, x} * {{SUM_W{1'b0}}, RECIP_NINE};
    return prod[23:16];
  endfunction

endpackage

### rtl/rgb_box_blur_3x3_top.sv
// 3x3 box blur on an RGB pixel stream.
// Input channel: in_valid / in_stall with red_in, green_in, blue_in, one pixel
// per transaction in raster order. Output channel: out_valid / out_stall with
// red_out, green_out, blue_out and frame_end; one transaction per interior
// pixel (row and column not on the border), frame_end on the last one.
// Each result is floor(sum/9) of the 3x3 neighborhood per channel.
// Throughput: one pixel per cycle while out_stall is low. The line buffer is
// a single RAM holding the two previous rows side by side, read once and
// written once per pixel. Pipeline: three register stages (line buffer read,
// window sum, divide).
// Border pixels produce no transaction.
// Configuration: cfg_wr_en with cfg_index 0 (image_width) or 1
// (image_height); a write restarts the image at row 0, column 0. Write only
// while the pipeline is empty. Width is clamped to 3..MAX_WIDTH, height >= 3.
// Reset: position counters cleared, width 1024, height 768, pipeline empty.
// Stall: out_stall holds the result; back-pressure reaches in_stall only
// once all internal stages are full.
module rgb_box_blur_3x3_top import rbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           red_in,
  input  logic [7:0]           green_in,
  input  logic [7:0]           blue_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           red_out,
  output logic [7:0]           green_out,
  output logic [7:0]           blue_out,
  output logic                 frame_end
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [10:0]   image_width;
  logic [15:0]   image_height;
  logic [CW-1:0] col_cnt;
  logic [15:0]   row_cnt;
  logic [CW-1:0] w_last;
  logic [15:0]   h_last;
  logic          cfg_hit;
  logic          in_go;

  logic          s1_valid;
  pix_t          s1_pix;
  logic [CW-1:0] s1_addr;
  logic          s1_emit;
  logic          s1_last;
  logic          s1_go;
  logic [47:0]   lb_rd;
  pix_t          lb_up;
  pix_t          lb_mid;

  logic          s2_free;
  logic          s2_valid;
  s2_t           s2;
  logic          out_free;

  always_comb begin
    if (image_width < 11'd3) begin
      w_last = CW'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width - 11'd1);
    end
    h_last = (image_height < 16'd3) ? 16'd2 : image_height - 16'd1;
  end

  assign cfg_hit  = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign s1_go    = s1_valid && (!s1_emit || s2_free);
  assign in_stall = s1_valid && !s1_go;
  assign in_go    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_go) begin
      if (col_cnt == w_last) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == h_last) ? 16'd0 : row_cnt + 16'd1;
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_go) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_pix  <= '{r: red_in, g: green_in, b: blue_in};
      s1_addr <= col_cnt;
      s1_emit <= (row_cnt >= 16'd2) && (col_cnt >= CW'(2));
      s1_last <= (row_cnt == h_last) && (col_cnt == w_last);
    end
  end

  // entry holds {row above, row two above} for one column
  rbb_ram #(
    .WIDTH(48),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .wr_en  (s1_go),
    .wr_addr(s1_addr),
    .wr_data({s1_pix, lb_mid}),
    .rd_en  (in_go),
    .rd_addr(col_cnt),
    .rd_data(lb_rd)
  );

  assign lb_mid = lb_rd[47:24];
  assign lb_up  = lb_rd[23:0];

  rbb_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_go),
    .emit    (s1_emit),
    .last    (s1_last),
    .up      (lb_up),
    .mid     (lb_mid),
    .cur     (s1_pix),
    .out_free(out_free),
    .s2_free (s2_free),
    .s2_valid(s2_valid),
    .s2      (s2)
  );

  rbb_mean u_mean (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2       (s2),
    .out_stall(out_stall),
    .out_free (out_free),
    .out_valid(out_valid),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out),
    .frame_end(frame_end)
  );

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt <= w_last)
    else $error("column counter past image width");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (col_cnt == '0) && (row_cnt == 16'd0))
    else $error("register write did not restart the image");

  a_last_is_interior: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last |-> s1_emit)
    else $error("frame end flagged on a border pixel");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_emit && s2_valid && out_valid && out_stall)
    else $error("input stalled with free pipeline stage");
`endif

endmodule

### rtl/rbb_ram.sv
module rbb_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/rbb_window.sv
module rbb_window import rbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic emit,
  input  logic last,
  input  pix_t up,
  input  pix_t mid,
  input  pix_t cur,
  input  logic out_free,
  output logic s2_free,
  output logic s2_valid,
  output s2_t  s2
);

  pix_t col0 [3];
  pix_t col1 [3];
  pix_t smp  [9];
  sum_t sums_next;

  always_comb begin
    smp[0] = col0[0];
    smp[1] = col0[1];
    smp[2] = col0[2];
    smp[3] = col1[0];
    smp[4] = col1[1];
    smp[5] = col1[2];
    smp[6] = up;
    smp[7] = mid;
    smp[8] = cur;
    sums_next = '0;
    for (int k = 0; k < 9; k++) begin
      sums_next.r = sums_next.r + {4'd0, smp[k].r};
      sums_next.g = sums_next.g + {4'd0, smp[k].g};
      sums_next.b = sums_next.b + {4'd0, smp[k].b};
    end
  end

  assign s2_free = !s2_valid || out_free;

  always_ff @(posedge clk) begin
    if (advance) begin
      col0[0] <= col1[0];
      col0[1] <= col1[1];
      col0[2] <= col1[2];
      col1[0] <= up;
      col1[1] <= mid;
      col1[2] <= cur;
    end
    if (advance && emit) begin
      s2.sums <= sums_next;
      s2.last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance && emit) begin
      s2_valid <= 1'b1;
    end else if (out_free) begin
      s2_valid <= 1'b0;
    end
  end

endmodule

### rtl/rbb_mean.sv
module rbb_mean import rbb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s2_valid,
  input  s2_t        s2,
  input  logic       out_stall,
  output logic       out_free,
  output logic       out_valid,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       frame_end
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (s2_valid && out_free) begin
      red_out   <= div9(s2.sums.r);
      green_out <= div9(s2.sums.g);
      blue_out  <= div9(s2.sums.b);
      frame_end <= s2.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### tb/sv/rgb_box_blur_3x3_top_tb.sv
module rgb_box_blur_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbb_pkg::*;

  localparam int unsigned MAXW        = 1024;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned DRAIN_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } blur_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           red_in = '0;
  logic [7:0]           green_in = '0;
  logic [7:0]           blue_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           red_out;
  logic [7:0]           green_out;
  logic [7:0]           blue_out;
  logic                 frame_end;

  rgb_box_blur_3x3_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .frame_end (frame_end)
  );

  always #1 clk = ~clk;

  // blur predictor state
  logic [10:0]  img_w_reg = WIDTH_RESET;
  logic [15:0]  img_h_reg = HEIGHT_RESET;
  pix_t         upper_row [MAXW];
  pix_t         middle_row [MAXW];
  pix_t         win_cols [6];
  int unsigned  col_pos = 0;
  int unsigned  row_pos = 0;

  pix_t         pixel_queue [$];
  blur_result_t blur_expected [$];
  pix_t         next_px;
  blur_result_t seen;
  blur_result_t want;
  int unsigned  errors = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  initial begin
    for (int k = 0; k < 6; k++) win_cols[k] = '0;
  end

  function automatic bit roll_pct(input int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      IDLE_BOTH: begin send_idle_pct = 33; recv_stall_pct = 33; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  function automatic void blur_accept(input pix_t px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int unsigned  sr;
    int unsigned  sg;
    int unsigned  sb;
    pix_t         samp [9];
    blur_result_t res;
    w = img_w_reg;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    h = (img_h_reg < 3) ? 3 : img_h_reg;
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    for (int k = 0; k < 6; k++) samp[k] = win_cols[k];
    samp[6] = upper_row[c];
    samp[7] = middle_row[c];
    samp[8] = px;
    upper_row[c]  = middle_row[c];
    middle_row[c] = px;
    if (r >= 2 && c >= 2) begin
      sr = 0;
      sg = 0;
      sb = 0;
      for (int k = 0; k < 9; k++) begin
        sr += samp[k].r;
        sg += samp[k].g;
        sb += samp[k].b;
      end
      res.r    = 8'(sr / 9);
      res.g    = 8'(sg / 9);
      res.b    = 8'(sb / 9);
      res.last = (r == h - 1) && (c == w - 1);
      blur_expected.push_back(res);
    end
    for (int k = 0; k < 6; k++) win_cols[k] = samp[k + 3];
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_t rand_px();
    pix_t p;
    p.r = rand_chan();
    p.g = rand_chan();
    p.b = rand_chan();
    return p;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) blur_accept({red_in, green_in, blue_in});
      if (!in_valid || !in_stall) begin
        if (pixel_queue.size() != 0 && !roll_pct(send_idle_pct)) begin
          next_px = pixel_queue.pop_front();
          in_valid <= 1'b1;
          red_in   <= next_px.r;
          green_in <= next_px.g;
          blue_in  <= next_px.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = {red_out, green_out, blue_out, frame_end};
        if (blur_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected transaction, actual r=%h g=%h b=%h end=%b",
                     $time, seen.r, seen.g, seen.b, seen.last);
        end else begin
          want = blur_expected.pop_front();
          if (seen.r !== want.r || seen.g !== want.g || seen.b !== want.b ||
              seen.last !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: expected r=%h g=%h b=%h end=%b, actual r=%h g=%h b=%h end=%b",
                       $time, want.r, want.g, want.b, want.last,
                       seen.r, seen.g, seen.b, seen.last);
          end
        end
      end
      out_stall <= roll_pct(recv_stall_pct);
    end
  end

  task automatic drain(input int unsigned settle);
    int unsigned n;
    n = 0;
    while ((pixel_queue.size() != 0 || in_valid || blur_expected.size() != 0) &&
           n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (blur_expected.size() != 0) begin
      errors += blur_expected.size();
      $display("%0t: expected %0d more transactions, actual none", $time,
               blur_expected.size());
      blur_expected.delete();
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_WIDTH) begin
      img_w_reg = val[10:0];
      col_pos = 0;
      row_pos = 0;
    end else if (idx == REG_HEIGHT) begin
      img_h_reg = val;
      col_pos = 0;
      row_pos = 0;
    end
    @(negedge clk);
  endtask

  task automatic run_phase(input idle_mode_t mode, input logic [15:0] wval,
                           input logic [15:0] hval, input int unsigned count,
                           input bit split);
    drain(SETTLE);
    set_idle(mode);
    write_reg(REG_WIDTH, wval);
    write_reg(REG_HEIGHT, hval);
    for (int unsigned i = 0; i < count; i++) begin
      if (split && i == count / 2) begin
        // hold off until the block is empty, then poke an unmapped index mid-image
        drain(SETTLE);
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
      end
      pixel_queue.push_back(rand_px());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    pix_t        p;
    int unsigned w;
    int unsigned h;
    int unsigned ew;
    int unsigned eh;
    logic [15:0] wval;
    wait (!rst);
    @(negedge clk);
    set_idle(IDLE_NONE);

    // a few pixels at the reset geometry leave the counters mid-row
    for (int k = 0; k < 3; k++) pixel_queue.push_back(rand_px());
    drain(SETTLE);
    write_reg(REG_WIDTH, 16'd3);
    write_reg(REG_HEIGHT, 16'd3);
    for (int k = 0; k < 9; k++) pixel_queue.push_back('{8'hff, 8'hff, 8'hff});
    drain(SETTLE);
    // below-range width and height both clamp to 3
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_HEIGHT, 16'd2);
    for (int k = 0; k < 9; k++) begin
      p.r = (k % 2) ? 8'hff : 8'h00;
      p.g = 8'(k * 31);
      p.b = 8'(255 - k);
      pixel_queue.push_back(p);
    end

    // wide rows at below-range height, then over-range width, then maximum height
    run_phase(IDLE_BOTH, 16'd64, 16'd0, 3 * 64 + 10, 1'b0);
    run_phase(IDLE_SEND, 16'hffff, 16'd3, 40, 1'b1);
    run_phase(IDLE_RECV, 16'd3, 16'hffff, 60, 1'b0);

    for (int unsigned ph = 0; ph < 12; ph++) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 9);
      h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 7);
      ew = (w < 3) ? 3 : w;
      eh = (h < 3) ? 3 : h;
      wval = 16'(w);
      if ($urandom_range(1)) wval[15:11] = 5'($urandom);
      run_phase(idle_mode_t'(ph % 4), wval, 16'(h),
                ew * eh * $urandom_range(1, 2) + $urandom_range(2 * ew), (ph % 5) == 2);
    end

    drain(2 * SETTLE);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
